### src/fmap_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and register codes of the four-level page map engine
// no dependencies; imported by every module of the block except fmap_ram

package fmap_pkg;

	// pool size; must stay a power of two so that frame selection is a mask
	localparam int TABLE_FRAMES      = 64;
	localparam int ENTRIES_PER_TABLE = 512;

	localparam int IDX_W       = $clog2(ENTRIES_PER_TABLE);
	localparam int FRAME_W     = $clog2(TABLE_FRAMES);
	localparam int NF_W        = $clog2(TABLE_FRAMES + 1);
	localparam int ADDR_W      = FRAME_W + IDX_W;
	localparam int STORE_DEPTH = TABLE_FRAMES * ENTRIES_PER_TABLE;

	localparam int ENTRY_W   = 48;
	localparam int VPAGE_W   = 36;
	localparam int PPAGE_W   = 20;
	localparam int COUNT_W   = 7;
	localparam int LEAF_W    = 32;
	localparam int ADDED_W   = 2;
	localparam int LEVEL_W   = 2;
	localparam int PAGE_SHIFT = 12;

	localparam int S_DATA_W = 64;
	localparam int M_DATA_W = 40;

	localparam logic [COUNT_W-1:0]    MAX_PAGES = 7'd64;
	localparam logic [PAGE_SHIFT-1:0] DESC_LOW  = 12'h003;
	localparam logic [LEVEL_W-1:0]    TOP_LEVEL = 2'd3;

	// configuration bus
	localparam int APB_AW = 4;
	localparam int APB_DW = 64;
	localparam logic REG_LEAF_ATTR = 1'b0;
	localparam logic REG_POOL_BASE = 1'b1;

	typedef struct packed {
		logic [LEAF_W-1:0]  leaf_attr;
		logic [VPAGE_W-1:0] pool_base;
	} cfg_t;

	typedef struct packed {
		logic [NF_W-1:0] next_free;
		logic            busy;
	} walk_stat_t;

endpackage

### src/fmap_ram.sv
`timescale 1ns / 1ps
// generic single-port synchronous ram with registered read data
// no dependencies

module fmap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

### src/fmap_cfg.sv
`timescale 1ns / 1ps
// apb-style register file: leaf attributes and pool base page
// depends on fmap_pkg

module fmap_cfg import fmap_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [LEAF_W-1:0]  leaf_attr_q;
	logic [VPAGE_W-1:0] pool_base_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// registers sit at 8-byte steps, selected by address bit 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_attr_q <= '0;
			pool_base_q <= '0;
		end else if (wr_en) begin
			case (paddr[3])
				REG_LEAF_ATTR: leaf_attr_q <= pwdata[LEAF_W-1:0];
				REG_POOL_BASE: pool_base_q <= pwdata[VPAGE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			REG_LEAF_ATTR: prdata = {{(APB_DW-LEAF_W){1'b0}}, leaf_attr_q};
			REG_POOL_BASE: prdata = {{(APB_DW-VPAGE_W){1'b0}}, pool_base_q};
			default:       prdata = '0;
		endcase
	end

	assign cfg.leaf_attr = leaf_attr_q;
	assign cfg.pool_base = pool_base_q;

endmodule

### src/fmap_walk.sv
`timescale 1ns / 1ps
// table walk sequencer: reads, allocates, clears and links tables, writes leaves
// depends on fmap_pkg and fmap_ram

module fmap_walk import fmap_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,
	output logic                m_tuser,
	output logic                m_tlast,
	output walk_stat_t          stat
);

	typedef enum logic [7:0] {
		ST_WIPE = 8'b0000_0001,
		ST_IDLE = 8'b0000_0010,
		ST_RD   = 8'b0000_0100,
		ST_CHK  = 8'b0000_1000,
		ST_CLR  = 8'b0001_0000,
		ST_LINK = 8'b0010_0000,
		ST_LEAF = 8'b0100_0000,
		ST_FAIL = 8'b1000_0000
	} state_t;

	state_t               state_q;
	logic [VPAGE_W-1:0]   vp_q;
	logic [PPAGE_W-1:0]   pp_q;
	logic [COUNT_W-1:0]   rem_q;
	logic [LEVEL_W-1:0]   lvl_q;
	logic [FRAME_W-1:0]   frame_q;
	logic [ADDED_W-1:0]   added_q;
	logic [NF_W-1:0]      next_free_q;
	logic [NF_W-1:0]      nf_q;
	logic [ADDR_W-1:0]    clr_addr_q;

	logic                 m_tvalid_q;
	logic                 m_tuser_q;
	logic                 m_tlast_q;
	logic [LEAF_W-1:0]    m_leaf_q;
	logic [ADDED_W-1:0]   m_added_q;

	logic [IDX_W-1:0]     idx;
	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_addr;
	logic [ENTRY_W-1:0]   ram_wdata;
	logic [ENTRY_W-1:0]   ram_rdata;
	logic [FRAME_W-1:0]   hit_frame;
	logic [VPAGE_W-1:0]   desc_page;
	logic [LEAF_W-1:0]    leaf;
	logic [COUNT_W-1:0]   cnt_in;
	logic [COUNT_W-1:0]   cnt_clamp;
	logic                 out_free;
	logic                 m_load;
	logic                 pool_empty;
	logic                 accept;

	// index of the current level out of the virtual page
	always_comb begin
		case (lvl_q)
			2'd3:    idx = vp_q[4*IDX_W-1:3*IDX_W];
			2'd2:    idx = vp_q[3*IDX_W-1:2*IDX_W];
			2'd1:    idx = vp_q[2*IDX_W-1:IDX_W];
			default: idx = vp_q[IDX_W-1:0];
		endcase
	end

	assign hit_frame  = ram_rdata[PAGE_SHIFT +: FRAME_W] - cfg.pool_base[FRAME_W-1:0];
	assign desc_page  = cfg.pool_base + {{(VPAGE_W-NF_W){1'b0}}, nf_q};
	assign leaf       = {pp_q, {PAGE_SHIFT{1'b0}}} | cfg.leaf_attr;
	assign out_free   = !m_tvalid_q || m_tready;
	assign m_load     = out_free && ((state_q == ST_LEAF) || (state_q == ST_FAIL));
	assign pool_empty = (next_free_q == NF_W'(TABLE_FRAMES));
	assign cnt_in     = s_tdata[VPAGE_W+PPAGE_W +: COUNT_W];
	assign cnt_clamp  = (cnt_in > MAX_PAGES) ? MAX_PAGES : cnt_in;
	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;

	// memory port
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = '0;
		ram_addr  = {frame_q, idx};
		case (state_q)
			ST_WIPE, ST_CLR: begin
				ram_we   = 1'b1;
				ram_addr = clr_addr_q;
			end
			ST_LINK: begin
				ram_we    = 1'b1;
				ram_wdata = {desc_page, DESC_LOW};
			end
			ST_LEAF: begin
				ram_we    = out_free;
				ram_wdata = {{(ENTRY_W-LEAF_W){1'b0}}, leaf};
			end
			default: ;
		endcase
	end

	fmap_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WIPE;
			clr_addr_q  <= '0;
			next_free_q <= NF_W'(1);
			m_tvalid_q  <= 1'b0;
		end else begin
			// output register loads a result or holds until taken
			m_tvalid_q <= m_load || (m_tvalid_q && !m_tready);
			case (state_q)
				ST_WIPE: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && cnt_clamp != '0) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (ram_rdata != '0) begin
						state_q <= (lvl_q == 2'd1) ? ST_LEAF : ST_RD;
					end else if (pool_empty) begin
						state_q <= ST_FAIL;
					end else begin
						clr_addr_q <= {next_free_q[FRAME_W-1:0], {IDX_W{1'b0}}};
						state_q    <= ST_CLR;
					end
				end
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q[IDX_W-1:0] == '1) begin
						state_q <= ST_LINK;
					end
				end
				ST_LINK: begin
					next_free_q <= next_free_q + 1'b1;
					state_q     <= (lvl_q == 2'd1) ? ST_LEAF : ST_RD;
				end
				ST_LEAF: begin
					if (out_free) begin
						state_q <= (rem_q == COUNT_W'(1)) ? ST_IDLE : ST_RD;
					end
				end
				ST_FAIL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// walk context and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					vp_q    <= s_tdata[VPAGE_W-1:0];
					pp_q    <= s_tdata[VPAGE_W +: PPAGE_W];
					rem_q   <= cnt_clamp;
					lvl_q   <= TOP_LEVEL;
					frame_q <= '0;
					added_q <= '0;
				end
			end
			ST_CHK: begin
				nf_q <= next_free_q;
				if (ram_rdata != '0) begin
					frame_q <= hit_frame;
					lvl_q   <= lvl_q - 1'b1;
				end
			end
			ST_LINK: begin
				frame_q <= nf_q[FRAME_W-1:0];
				added_q <= added_q + 1'b1;
				lvl_q   <= lvl_q - 1'b1;
			end
			ST_LEAF: begin
				if (out_free) begin
					m_tuser_q <= 1'b0;
					m_leaf_q  <= leaf;
					m_added_q <= added_q;
					m_tlast_q <= (rem_q == COUNT_W'(1));
					vp_q      <= vp_q + 1'b1;
					pp_q      <= pp_q + 1'b1;
					rem_q     <= rem_q - 1'b1;
					lvl_q     <= TOP_LEVEL;
					frame_q   <= '0;
					added_q   <= '0;
				end
			end
			ST_FAIL: begin
				if (out_free) begin
					m_tuser_q <= 1'b1;
					m_leaf_q  <= '0;
					m_added_q <= added_q;
					m_tlast_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;
	assign m_tdata  = {{(M_DATA_W-LEAF_W-ADDED_W){1'b0}}, m_added_q, m_leaf_q};

	assign stat.next_free = next_free_q;
	assign stat.busy      = (state_q != ST_IDLE);

endmodule

### src/four_level_page_map_engine_top.sv
`timescale 1ns / 1ps
// top level of the four-level page map engine
// depends on fmap_pkg, fmap_cfg, fmap_walk (which holds fmap_ram)

// usage:
// - s_* stream: one mapping request per item (start virtual page, start physical
//   page, page count); counts above 64 are clamped, a zero count yields nothing
// - m_* stream: one result per page, tlast on the final one; tuser high marks a
//   pool-exhausted result, which also carries tlast and ends the request
// - apb port: leaf attributes at 0x0, pool base page at 0x8; write only while idle
// - the tables live in one single-port ram (64 frames of 512 entries); each
//   walk step is a read state followed by a check state, so a page whose tables
//   all exist passes three levels of read and check, then one leaf write
// - every newly allocated table adds 512 clearing writes to the frame through
//   the same ram port, then one write that links it
// - after reset the whole ram is cleared, all 32768 entries, one entry a cycle;
//   s_tready stays low until that pass ends, apb writes are taken throughout
// - s_tready is high only between requests; a request is accepted while the
//   last result of the previous one still waits in the output register
// - when the receiver stalls, the walk halts at the leaf write of the next page
//   until the output register frees up; nothing is dropped

module four_level_page_map_engine_top import fmap_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// apb configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	// request stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // virt_page[35:0], phys_page[55:36], page_count[62:56]
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // leaf_value[31:0], tables_added[33:32]
	output logic                m_tuser,  // status
	output logic                m_tlast
);

	cfg_t       cfg;
	walk_stat_t stat;

	// register file
	fmap_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// walk sequencer with the table store
	fmap_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.stat    (stat)
	);

	// pool counter stays within the pool and never hands out the root
	a_pool_range: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.next_free != '0) && (stat.next_free <= NF_W'(TABLE_FRAMES)))
		else $error("pool counter out of range");

	// a request with pages starts a walk and closes the request port
	a_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tdata[62:56] != '0)) |=> (!s_tready && stat.busy))
		else $error("request accepted but no walk started");

	// an exhausted-pool result ends the request and carries no leaf
	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && (m_tdata[LEAF_W-1:0] == '0)))
		else $error("error result without last or with a leaf value");

endmodule
